// File: src/accel_highpass_velocity_integrator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ACCEL_HIGHPASS_VELOCITY_INTEGRATOR_MACROS_SVH
`define ACCEL_HIGHPASS_VELOCITY_INTEGRATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Assert a property on a named clock, held off while the named reset is low.
`define AHVI_ASSERT_CLK(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (prop)) \
		else $error("ahvi assertion failed");

// Assert a property on clk, held off during arst_n.
`define AHVI_ASSERT(label, prop) `AHVI_ASSERT_CLK(label, clk, arst_n, prop)

`else

`define AHVI_ASSERT_CLK(label, clock, rst_n, prop)
`define AHVI_ASSERT(label, prop)

`endif

`endif

// File: src/ahvi_pkg.sv
// ----------------------------------------------------------------------------
// ahvi_pkg
// Shared constants, sequencer codes and saturation helpers.
// ----------------------------------------------------------------------------
package ahvi_pkg;

	localparam int FRAC_BITS  = 16;          // fraction bits of the Q16.16 state
	localparam int COEF_SH    = 16;          // Q0.16 coefficient scaling
	localparam int TRAP_SH    = 17;          // Q0.16 step and the halving of the trapezoid
	localparam int ACC_W      = 66;
	localparam int MUL_A_W    = 25;
	localparam int MUL_B_W    = 18;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int SPLIT_W    = 24;          // low slice of a wide operand
	localparam int SQ_MID_SH  = 17;          // cross term of a square, 2*h*l << 16
	localparam int SQ_HI_SH   = 32;
	localparam int SMP_W      = 16;
	localparam int LP_W       = 48;
	localparam int SUM_W      = LP_W + 1;
	localparam int WIDE_W     = LP_W + 2;
	localparam int VEL_W      = 32;
	localparam int HALF_W     = VEL_W / 2;
	localparam int ROOT_BITS  = 7;
	localparam int RAD_W      = 2 * ROOT_BITS;
	localparam int RCNT_W     = $clog2(ROOT_BITS);
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0]  REG_ALPHA       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0]  REG_TIME_STEP   = CFG_IDX_W'(1);
	localparam logic [CFG_DATA_W-1:0] ALPHA_RESET     = CFG_DATA_W'(45875);
	localparam logic [CFG_DATA_W-1:0] TIME_STEP_RESET = CFG_DATA_W'(6554);
	localparam logic [RAD_W-1:0]      RAD_SAT         = {RAD_W{1'b1}};

	typedef enum logic [4:0] {
		ST_IDLE, ST_LP0, ST_LP1, ST_LP2, ST_LPW, ST_HP, ST_VS, ST_V0, ST_V1,
		ST_VW, ST_PS, ST_P0, ST_P1, ST_PW, ST_SQ0, ST_SQ1, ST_SQ2, ST_CHK,
		ST_ROOT, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		A_LPLO, A_LPHI, A_SAMPLE, A_SUMLO, A_SUMHI, A_ABSLO, A_ABSHI, A_TRIAL
	} a_sel_t;

	typedef enum logic [2:0] {
		B_ALPHA, B_ALPHAC, B_TS, B_ABSLO, B_ABSHI, B_TRIAL
	} b_sel_t;

	typedef enum logic [2:0] {
		SH_0, SH_SQMID, SH_SPLIT, SH_SQHI, SH_FRAC
	} sh_sel_t;

	typedef enum logic [3:0] {
		W_NONE, W_LP, W_HP, W_VSUM, W_VEL, W_PSUM, W_POS, W_ROOTINIT, W_ROOT
	} wr_op_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic              mac_en;
		logic              mac_clr;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		sh_sel_t           sh_sel;
		wr_op_t            wr_op;
		logic              axis;
		logic [RCNT_W-1:0] bit_idx;
	} ctrl_t;

	function automatic logic signed [LP_W-1:0] sat_to_48(input logic signed [WIDE_W-1:0] v);
		logic all0;
		logic all1;
		all0 = ~|v[WIDE_W-1:LP_W-1];
		all1 = &v[WIDE_W-1:LP_W-1];
		if (all0 || all1)
			return v[LP_W-1:0];
		return v[WIDE_W-1] ? {1'b1, {(LP_W-1){1'b0}}} : {1'b0, {(LP_W-1){1'b1}}};
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_to_32(input logic signed [WIDE_W-1:0] v);
		logic all0;
		logic all1;
		all0 = ~|v[WIDE_W-1:VEL_W-1];
		all1 = &v[WIDE_W-1:VEL_W-1];
		if (all0 || all1)
			return v[VEL_W-1:0];
		return v[WIDE_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
	endfunction

endpackage

// File: src/ahvi_if.sv
// ----------------------------------------------------------------------------
// ahvi channel interfaces
// Valid/ready channels for acceleration samples and integrator results.
// ----------------------------------------------------------------------------
interface ahvi_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;

	modport source (output valid, output accel_x, output accel_y, input ready);
	modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

interface ahvi_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] disp_x;
	logic signed [31:0] disp_y;
	logic        [6:0]  speed;

	modport source (output valid, output vel_x, output vel_y, output disp_x,
		output disp_y, output speed, input ready);
	modport sink   (input valid, input vel_x, input vel_y, input disp_x,
		input disp_y, input speed, output ready);
endinterface

// File: src/ahvi_mac.sv
// ----------------------------------------------------------------------------
// ahvi_mac
// Shared signed multiplier with shift-and-accumulate register.
// ----------------------------------------------------------------------------
module ahvi_mac (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 clr,
	input  ahvi_pkg::sh_sel_t                    sh_sel,
	input  logic signed [ahvi_pkg::MUL_A_W-1:0]  op_a,
	input  logic signed [ahvi_pkg::MUL_B_W-1:0]  op_b,
	output logic signed [ahvi_pkg::PROD_W-1:0]   prod,
	output logic signed [ahvi_pkg::ACC_W-1:0]    acc
);

	logic signed [ahvi_pkg::ACC_W-1:0] prod_ext;
	logic signed [ahvi_pkg::ACC_W-1:0] shifted;
	logic signed [ahvi_pkg::ACC_W-1:0] acc_q;

	assign prod     = op_a * op_b;
	assign prod_ext = ahvi_pkg::ACC_W'(prod);

	always_comb begin
		case (sh_sel)
			ahvi_pkg::SH_0:     shifted = prod_ext;
			ahvi_pkg::SH_SQMID: shifted = prod_ext <<< ahvi_pkg::SQ_MID_SH;
			ahvi_pkg::SH_SPLIT: shifted = prod_ext <<< ahvi_pkg::SPLIT_W;
			ahvi_pkg::SH_SQHI:  shifted = prod_ext <<< ahvi_pkg::SQ_HI_SH;
			ahvi_pkg::SH_FRAC:  shifted = prod_ext <<< ahvi_pkg::FRAC_BITS;
			default:            shifted = prod_ext;
		endcase
	end

	// start a fresh sum on clr, otherwise add the shifted partial product
	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= clr ? shifted : acc_q + shifted;
		end
	end

	assign acc = acc_q;

endmodule

// File: src/ahvi_seq.sv
// ----------------------------------------------------------------------------
// ahvi_seq
// Step sequencer driving the shared multiplier and state updates.
// ----------------------------------------------------------------------------
module ahvi_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            out_ready,
	output ahvi_pkg::ctrl_t ctrl
);

	ahvi_pkg::state_t               state_q;
	ahvi_pkg::state_t               state_d;
	logic                           ax_q;
	logic [ahvi_pkg::RCNT_W-1:0]    rcnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ahvi_pkg::ST_IDLE: if (start) state_d = ahvi_pkg::ST_LP0;
			ahvi_pkg::ST_LP0:  state_d = ahvi_pkg::ST_LP1;
			ahvi_pkg::ST_LP1:  state_d = ahvi_pkg::ST_LP2;
			ahvi_pkg::ST_LP2:  state_d = ahvi_pkg::ST_LPW;
			ahvi_pkg::ST_LPW:  state_d = ahvi_pkg::ST_HP;
			ahvi_pkg::ST_HP:   state_d = ahvi_pkg::ST_VS;
			ahvi_pkg::ST_VS:   state_d = ahvi_pkg::ST_V0;
			ahvi_pkg::ST_V0:   state_d = ahvi_pkg::ST_V1;
			ahvi_pkg::ST_V1:   state_d = ahvi_pkg::ST_VW;
			ahvi_pkg::ST_VW:   state_d = ahvi_pkg::ST_PS;
			ahvi_pkg::ST_PS:   state_d = ahvi_pkg::ST_P0;
			ahvi_pkg::ST_P0:   state_d = ahvi_pkg::ST_P1;
			ahvi_pkg::ST_P1:   state_d = ahvi_pkg::ST_PW;
			ahvi_pkg::ST_PW:   state_d = ax_q ? ahvi_pkg::ST_SQ0 : ahvi_pkg::ST_LP0;
			ahvi_pkg::ST_SQ0:  state_d = ahvi_pkg::ST_SQ1;
			ahvi_pkg::ST_SQ1:  state_d = ahvi_pkg::ST_SQ2;
			ahvi_pkg::ST_SQ2:  state_d = ax_q ? ahvi_pkg::ST_CHK : ahvi_pkg::ST_SQ0;
			ahvi_pkg::ST_CHK:  state_d = ahvi_pkg::ST_ROOT;
			ahvi_pkg::ST_ROOT: if (rcnt_q == '0) state_d = ahvi_pkg::ST_DONE;
			ahvi_pkg::ST_DONE: if (out_ready) state_d = ahvi_pkg::ST_IDLE;
			default:           state_d = ahvi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahvi_pkg::ST_IDLE;
			ax_q    <= 1'b0;
			rcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			// flip axis after the last step of each per-axis pass
			if (state_q == ahvi_pkg::ST_PW || state_q == ahvi_pkg::ST_SQ2) begin
				ax_q <= ~ax_q;
			end
			if (state_q == ahvi_pkg::ST_CHK) begin
				rcnt_q <= ahvi_pkg::RCNT_W'(ahvi_pkg::ROOT_BITS - 1);
			end else if (state_q == ahvi_pkg::ST_ROOT) begin
				rcnt_q <= rcnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		ctrl         = '0;
		ctrl.a_sel   = ahvi_pkg::A_LPLO;
		ctrl.b_sel   = ahvi_pkg::B_ALPHA;
		ctrl.sh_sel  = ahvi_pkg::SH_0;
		ctrl.wr_op   = ahvi_pkg::W_NONE;
		ctrl.axis    = ax_q;
		ctrl.bit_idx = rcnt_q;
		case (state_q)
			ahvi_pkg::ST_IDLE: ctrl.idle = 1'b1;
			ahvi_pkg::ST_LP0: begin
				ctrl.mac_en  = 1'b1;
				ctrl.mac_clr = 1'b1;
			end
			ahvi_pkg::ST_LP1: begin
				ctrl.mac_en = 1'b1;
				ctrl.a_sel  = ahvi_pkg::A_LPHI;
				ctrl.sh_sel = ahvi_pkg::SH_SPLIT;
			end
			ahvi_pkg::ST_LP2: begin
				ctrl.mac_en = 1'b1;
				ctrl.a_sel  = ahvi_pkg::A_SAMPLE;
				ctrl.b_sel  = ahvi_pkg::B_ALPHAC;
				ctrl.sh_sel = ahvi_pkg::SH_FRAC;
			end
			ahvi_pkg::ST_LPW: ctrl.wr_op = ahvi_pkg::W_LP;
			ahvi_pkg::ST_HP:  ctrl.wr_op = ahvi_pkg::W_HP;
			ahvi_pkg::ST_VS:  ctrl.wr_op = ahvi_pkg::W_VSUM;
			ahvi_pkg::ST_V0, ahvi_pkg::ST_P0: begin
				ctrl.mac_en  = 1'b1;
				ctrl.mac_clr = 1'b1;
				ctrl.a_sel   = ahvi_pkg::A_SUMLO;
				ctrl.b_sel   = ahvi_pkg::B_TS;
			end
			ahvi_pkg::ST_V1, ahvi_pkg::ST_P1: begin
				ctrl.mac_en = 1'b1;
				ctrl.a_sel  = ahvi_pkg::A_SUMHI;
				ctrl.b_sel  = ahvi_pkg::B_TS;
				ctrl.sh_sel = ahvi_pkg::SH_SPLIT;
			end
			ahvi_pkg::ST_VW:  ctrl.wr_op = ahvi_pkg::W_VEL;
			ahvi_pkg::ST_PS:  ctrl.wr_op = ahvi_pkg::W_PSUM;
			ahvi_pkg::ST_PW:  ctrl.wr_op = ahvi_pkg::W_POS;
			ahvi_pkg::ST_SQ0: begin
				ctrl.mac_en  = 1'b1;
				ctrl.mac_clr = ~ax_q;
				ctrl.a_sel   = ahvi_pkg::A_ABSLO;
				ctrl.b_sel   = ahvi_pkg::B_ABSLO;
			end
			ahvi_pkg::ST_SQ1: begin
				ctrl.mac_en = 1'b1;
				ctrl.a_sel  = ahvi_pkg::A_ABSHI;
				ctrl.b_sel  = ahvi_pkg::B_ABSLO;
				ctrl.sh_sel = ahvi_pkg::SH_SQMID;
			end
			ahvi_pkg::ST_SQ2: begin
				ctrl.mac_en = 1'b1;
				ctrl.a_sel  = ahvi_pkg::A_ABSHI;
				ctrl.b_sel  = ahvi_pkg::B_ABSHI;
				ctrl.sh_sel = ahvi_pkg::SH_SQHI;
			end
			ahvi_pkg::ST_CHK: ctrl.wr_op = ahvi_pkg::W_ROOTINIT;
			ahvi_pkg::ST_ROOT: begin
				ctrl.a_sel = ahvi_pkg::A_TRIAL;
				ctrl.b_sel = ahvi_pkg::B_TRIAL;
				ctrl.wr_op = ahvi_pkg::W_ROOT;
			end
			ahvi_pkg::ST_DONE: ctrl.done = 1'b1;
			default: ;
		endcase
	end

endmodule

// File: src/accel_highpass_velocity_integrator.sv
// ----------------------------------------------------------------------------
// accel_highpass_velocity_integrator
// High-pass filtered X/Y acceleration, integrated twice into velocity,
// displacement and a saturated speed magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready channel carrying accel_x and accel_y (hundredths).
//   result : valid/ready channel carrying vel_x, vel_y, disp_x, disp_y
//            (signed Q16.16) and speed (integer part of |v|, 0..127).
//   cfg    : write port; index 0 is alpha, index 1 is time_step (Q0.16).
//            Writes to other indices are dropped. Write only while idle.
// Schedule: every multiply, for both axes, runs through one 25x18
//   multiply-accumulate unit: 13 steps per axis, 6 steps for the
//   squared speed, 1 range check and 7 trial-square steps for the root.
//   One sample is in flight at a time; sample.ready is high only while
//   the block is idle.
// Reset: all filter and integrator state clears to zero, alpha returns to
//   0.7 and time_step to 0.1.
// Stall: while result.ready is low the result holds and no new sample
//   is taken.
// ----------------------------------------------------------------------------
module accel_highpass_velocity_integrator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	ahvi_sample_if.sink                           sample,
	ahvi_result_if.source                         result,
	input  logic                                  cfg_wr_en,
	input  logic [ahvi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ahvi_pkg::CFG_DATA_W-1:0]       cfg_data
);

`include "accel_highpass_velocity_integrator_macros.svh"

	localparam int LPW  = ahvi_pkg::LP_W;
	localparam int SUMW = ahvi_pkg::SUM_W;
	localparam int WW   = ahvi_pkg::WIDE_W;
	localparam int VW   = ahvi_pkg::VEL_W;
	localparam int HW   = ahvi_pkg::HALF_W;
	localparam int AW   = ahvi_pkg::MUL_A_W;
	localparam int BW   = ahvi_pkg::MUL_B_W;
	localparam int SPW  = ahvi_pkg::SPLIT_W;
	localparam int RB   = ahvi_pkg::ROOT_BITS;
	localparam int RADW = ahvi_pkg::RAD_W;
	localparam int ACCW = ahvi_pkg::ACC_W;
	localparam int RAD_LO = 2 * ahvi_pkg::FRAC_BITS;

	ahvi_pkg::ctrl_t ctrl;

	// configuration
	logic [ahvi_pkg::CFG_DATA_W-1:0] alpha_q;
	logic [ahvi_pkg::CFG_DATA_W-1:0] ts_q;

	// per-axis filter and integrator state
	logic signed [LPW-1:0] lp_q   [2];
	logic signed [LPW-1:0] ph_q   [2];
	logic signed [VW-1:0]  vel_q  [2];
	logic signed [VW-1:0]  pvel_q [2];
	logic signed [VW-1:0]  pos_q  [2];

	// working registers
	logic signed [ahvi_pkg::SMP_W-1:0] smp_q [2];
	logic        [VW-1:0]              vabs_q [2];
	logic signed [LPW-1:0]             h_q;
	logic signed [SUMW-1:0]            sum_q;
	logic        [RADW-1:0]            rad_q;
	logic        [RB-1:0]              root_q;

	// shared unit
	logic signed [AW-1:0]                 op_a;
	logic signed [BW-1:0]                 op_b;
	logic signed [ahvi_pkg::PROD_W-1:0]   prod;
	logic signed [ACCW-1:0]               acc;

	logic                  ax;
	logic signed [LPW-1:0] lp_cur;
	logic [VW-1:0]         vabs_cur;
	logic [RB-1:0]         trial;
	logic signed [WW-1:0]  a_ext;
	logic signed [WW-1:0]  lp_raw;
	logic signed [WW-1:0]  h_raw;
	logic signed [WW-1:0]  vel_raw;
	logic signed [WW-1:0]  pos_raw;
	logic signed [SUMW-1:0] trap;
	logic                  rad_sat;
	logic                  root_hit;
	logic                  sample_xfer;

	ahvi_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sample.valid),
		.out_ready (result.ready),
		.ctrl      (ctrl)
	);

	ahvi_mac u_mac (
		.clk    (clk),
		.en     (ctrl.mac_en),
		.clr    (ctrl.mac_clr),
		.sh_sel (ctrl.sh_sel),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod   (prod),
		.acc    (acc)
	);

	assign ax          = ctrl.axis;
	assign lp_cur      = lp_q[ax];
	assign vabs_cur    = vabs_q[ax];
	assign trial       = root_q | (RB'(1) << ctrl.bit_idx);
	assign sample_xfer = sample.valid && sample.ready;

	// operand selection for the shared multiplier
	always_comb begin
		case (ctrl.a_sel)
			ahvi_pkg::A_LPLO:   op_a = $signed({1'b0, lp_cur[SPW-1:0]});
			// upper slice carries the sign of the low-pass value
			ahvi_pkg::A_LPHI:   op_a = AW'($signed(lp_cur[LPW-1:SPW]));
			ahvi_pkg::A_SAMPLE: op_a = AW'(smp_q[ax]);
			ahvi_pkg::A_SUMLO:  op_a = $signed({1'b0, sum_q[SPW-1:0]});
			ahvi_pkg::A_SUMHI:  op_a = sum_q[SUMW-1:SPW];
			ahvi_pkg::A_ABSLO:  op_a = $signed(AW'(vabs_cur[HW-1:0]));
			ahvi_pkg::A_ABSHI:  op_a = $signed(AW'(vabs_cur[VW-1:HW]));
			ahvi_pkg::A_TRIAL:  op_a = $signed(AW'(trial));
			default:            op_a = '0;
		endcase
	end

	always_comb begin
		case (ctrl.b_sel)
			ahvi_pkg::B_ALPHA:  op_b = $signed(BW'(alpha_q));
			// 65536 - alpha, which is 65536 itself when alpha is zero
			ahvi_pkg::B_ALPHAC: op_b = $signed(BW'(17'h10000 - {1'b0, alpha_q}));
			ahvi_pkg::B_TS:     op_b = $signed(BW'(ts_q));
			ahvi_pkg::B_ABSLO:  op_b = $signed(BW'(vabs_cur[HW-1:0]));
			ahvi_pkg::B_ABSHI:  op_b = $signed(BW'(vabs_cur[VW-1:HW]));
			ahvi_pkg::B_TRIAL:  op_b = $signed(BW'(trial));
			default:            op_b = '0;
		endcase
	end

	// scaled-down sums, floor by arithmetic shift
	assign a_ext   = WW'(smp_q[ax]) <<< ahvi_pkg::FRAC_BITS;
	assign lp_raw  = $signed(acc[ACCW-1:ahvi_pkg::COEF_SH]);
	assign h_raw   = a_ext - WW'(lp_cur);
	assign trap    = $signed(acc[ACCW-1:ahvi_pkg::TRAP_SH]);
	assign vel_raw = WW'(vel_q[ax]) + WW'(trap);
	assign pos_raw = WW'(pos_q[ax]) + WW'(trap);

	// speed only needs floor(sqrt(v^2 >> 2F)), capped at 127
	assign rad_sat  = |acc[ACCW-1:RAD_LO+RADW];
	assign root_hit = (prod[ahvi_pkg::PROD_W-1:0] <= ahvi_pkg::PROD_W'(rad_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ahvi_pkg::ALPHA_RESET;
			ts_q    <= ahvi_pkg::TIME_STEP_RESET;
			for (int i = 0; i < 2; i++) begin
				lp_q[i]   <= '0;
				ph_q[i]   <= '0;
				vel_q[i]  <= '0;
				pvel_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ahvi_pkg::REG_ALPHA:     alpha_q <= cfg_data;
					ahvi_pkg::REG_TIME_STEP: ts_q    <= cfg_data;
					default: ;
				endcase
			end
			case (ctrl.wr_op)
				ahvi_pkg::W_LP:   lp_q[ax] <= ahvi_pkg::sat_to_48(lp_raw);
				ahvi_pkg::W_VSUM: ph_q[ax] <= h_q;
				ahvi_pkg::W_VEL:  vel_q[ax] <= ahvi_pkg::sat_to_32(vel_raw);
				ahvi_pkg::W_PSUM: pvel_q[ax] <= vel_q[ax];
				ahvi_pkg::W_POS:  pos_q[ax] <= ahvi_pkg::sat_to_32(pos_raw);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			smp_q[0] <= sample.accel_x;
			smp_q[1] <= sample.accel_y;
		end
		case (ctrl.wr_op)
			ahvi_pkg::W_HP:   h_q <= ahvi_pkg::sat_to_48(h_raw);
			ahvi_pkg::W_VSUM: sum_q <= SUMW'(h_q) + SUMW'(ph_q[ax]);
			ahvi_pkg::W_PSUM: begin
				sum_q      <= SUMW'(vel_q[ax]) + SUMW'(pvel_q[ax]);
				vabs_q[ax] <= vel_q[ax][VW-1] ? (~vel_q[ax] + 1'b1) : vel_q[ax];
			end
			ahvi_pkg::W_ROOTINIT: begin
				rad_q  <= rad_sat ? ahvi_pkg::RAD_SAT : acc[RAD_LO+RADW-1:RAD_LO];
				root_q <= '0;
			end
			ahvi_pkg::W_ROOT: if (root_hit) root_q <= trial;
			default: ;
		endcase
	end

	assign sample.ready  = ctrl.idle;
	assign result.valid  = ctrl.done;
	assign result.vel_x  = vel_q[0];
	assign result.vel_y  = vel_q[1];
	assign result.disp_x = pos_q[0];
	assign result.disp_y = pos_q[1];
	assign result.speed  = root_q;

	// root bounds for the checks below
	logic [RADW:0]   root_sq;
	logic [RADW+1:0] root_next_sq;
	assign root_sq      = (RADW+1)'(root_q) * (RADW+1)'(root_q);
	assign root_next_sq = ((RADW+2)'(root_q) + 1'b1) * ((RADW+2)'(root_q) + 1'b1);

	`AHVI_ASSERT(a_busy_after_transfer, sample_xfer |=> !sample.ready)
	`AHVI_ASSERT(a_no_overlap, !(sample.ready && result.valid))
	`AHVI_ASSERT(a_root_low, result.valid |-> root_sq <= (RADW+1)'(rad_q))
	`AHVI_ASSERT(a_root_high, result.valid |-> root_next_sq > (RADW+2)'(rad_q))

endmodule

// File: tb/integrator_result_checker.sv
// ----------------------------------------------------------------------------
// integrator_result_checker
// Watches the sample, result and register channels of the velocity
// integrator, predicts every result from its own copy of the filter and
// integrator state, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module integrator_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	ahvi_sample_if                              smp,
	ahvi_result_if                              res,
	input  logic                                cfg_wr_en,
	input  logic [ahvi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ahvi_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  mismatches,
	output int                                  results_seen,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ahvi_pkg::*;

	typedef logic signed [95:0] wide_t;

	typedef struct packed {
		logic signed [LP_W-1:0]  lowpass;
		logic signed [LP_W-1:0]  prev_high;
		logic signed [VEL_W-1:0] velocity;
		logic signed [VEL_W-1:0] prev_velocity;
		logic signed [VEL_W-1:0] position;
	} axis_state_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] disp_x;
		logic signed [VEL_W-1:0] disp_y;
		logic [ROOT_BITS-1:0]    speed;
	} motion_t;

	logic [CFG_DATA_W-1:0] alpha_q;
	logic [CFG_DATA_W-1:0] step_q;
	axis_state_t           axis_x;
	axis_state_t           axis_y;
	motion_t               expected_motion[$];

	function automatic wide_t saturate(input wide_t v, input int bits);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// floor(sum * time_step / 2^17): the halving of the trapezoid is folded in
	function automatic wide_t trapezoid(input wide_t sum);
		return (sum * wide_t'(step_q)) >>> TRAP_SH;
	endfunction

	function automatic void advance_axis(inout axis_state_t st, input logic signed [15:0] accel);
		wide_t a;
		wide_t al;
		wide_t lp;
		wide_t h;
		wide_t v;
		wide_t p;
		a  = wide_t'(accel) <<< FRAC_BITS;
		al = wide_t'(alpha_q);
		lp = saturate((wide_t'(st.lowpass) * al + a * ((wide_t'(1) <<< COEF_SH) - al))
			>>> COEF_SH, LP_W);
		h  = saturate(a - lp, LP_W);
		v  = saturate(wide_t'(st.velocity) + trapezoid(h + wide_t'(st.prev_high)), VEL_W);
		p  = saturate(wide_t'(st.position) + trapezoid(v + wide_t'(st.velocity)), VEL_W);
		st.lowpass       = lp[LP_W-1:0];
		st.prev_high     = h[LP_W-1:0];
		st.prev_velocity = v[VEL_W-1:0];
		st.velocity      = v[VEL_W-1:0];
		st.position      = p[VEL_W-1:0];
	endfunction

	// integer part of |v|: largest k with k*k <= (vx^2 + vy^2) / 2^32, capped
	function automatic logic [ROOT_BITS-1:0] speed_of(input logic signed [VEL_W-1:0] vx,
			input logic signed [VEL_W-1:0] vy);
		wide_t whole;
		logic [ROOT_BITS-1:0] s;
		whole = (wide_t'(vx) * wide_t'(vx) + wide_t'(vy) * wide_t'(vy)) >>> (2 * FRAC_BITS);
		s = '0;
		for (int k = 1; k < (1 << ROOT_BITS); k++)
			if (wide_t'(k * k) <= whole)
				s = ROOT_BITS'(k);
		return s;
	endfunction

	function automatic motion_t predict_motion(input logic signed [15:0] ax,
			input logic signed [15:0] ay);
		motion_t m;
		advance_axis(axis_x, ax);
		advance_axis(axis_y, ay);
		m.vel_x  = axis_x.velocity;
		m.vel_y  = axis_y.velocity;
		m.disp_x = axis_x.position;
		m.disp_y = axis_y.position;
		m.speed  = speed_of(axis_x.velocity, axis_y.velocity);
		return m;
	endfunction

	function automatic int field_differs(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int      bad;
		motion_t want;
		if (!arst_n) begin
			alpha_q = ALPHA_RESET;
			step_q  = TIME_STEP_RESET;
			axis_x  = '0;
			axis_y  = '0;
			expected_motion.delete();
			mismatches   <= 0;
			results_seen <= 0;
			pending      <= 0;
		end else begin
			bad = 0;
			// unknown indices are dropped by the block, so drop them here too
			if (cfg_wr_en) begin
				if (cfg_index == REG_ALPHA)
					alpha_q = cfg_data;
				else if (cfg_index == REG_TIME_STEP)
					step_q = cfg_data;
			end
			// check the result before queueing a new sample taken at the same edge
			if (res.valid && res.ready) begin
				if (expected_motion.size() == 0) begin
					$display("%0t ns: result expected none, got vel %0d/%0d disp %0d/%0d speed %0d",
						$time, res.vel_x, res.vel_y, res.disp_x, res.disp_y, res.speed);
					bad++;
				end else begin
					want = expected_motion.pop_front();
					bad += field_differs("vel_x", 64'(want.vel_x), 64'(res.vel_x));
					bad += field_differs("vel_y", 64'(want.vel_y), 64'(res.vel_y));
					bad += field_differs("disp_x", 64'(want.disp_x), 64'(res.disp_x));
					bad += field_differs("disp_y", 64'(want.disp_y), 64'(res.disp_y));
					bad += field_differs("speed", 64'(want.speed), 64'(res.speed));
				end
				results_seen <= results_seen + 1;
			end
			if (smp.valid && smp.ready)
				expected_motion.push_back(predict_motion(smp.accel_x, smp.accel_y));
			mismatches <= mismatches + bad;
			pending    <= expected_motion.size();
		end
	end

endmodule

// File: tb/tb_accel_highpass_velocity_integrator.sv
// ----------------------------------------------------------------------------
// tb_accel_highpass_velocity_integrator
// Drives acceleration samples and coefficient writes into the integrator,
// with bursty sample traffic and a result sink that stalls on its own
// pattern; the result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_accel_highpass_velocity_integrator;
	timeunit 1ns;
	timeprecision 1ps;

	import ahvi_pkg::*;

	// first index above the defined registers; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_TIME_STEP + 1);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE_CYCLES = 60;   // a little over one sample's latency
	localparam int NUM_DIRECTED = 22;

	// corners of both axes: rails, sign flips, single steps, alternating bits,
	// a constant run that the high-pass has to bleed away
	localparam logic signed [15:0] DIRECTED_X [NUM_DIRECTED] = '{
		16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
		16'sh0001, 16'shffff, 16'sh5555, 16'shaaaa, 16'sh0000, 16'sh0000, 16'sh0000,
		16'sh0064, 16'sh0000, 16'sh0064, 16'shff9c, 16'sh7fff, 16'sh7fff, 16'sh7fff,
		16'sh0000
	};
	localparam logic signed [15:0] DIRECTED_Y [NUM_DIRECTED] = '{
		16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
		16'shffff, 16'sh0001, 16'shaaaa, 16'sh5555, 16'sh0000, 16'sh0000, 16'sh0000,
		16'sh0000, 16'sh0064, 16'sh0064, 16'shff9c, 16'sh0000, 16'sh0000, 16'sh0000,
		16'sh8000
	};

	typedef enum {PAT_NOISE, PAT_QUIET, PAT_HOLD, PAT_RAIL, PAT_RAMP} accel_pattern_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  smp_valid = 1'b0;
	logic signed [15:0]    smp_x     = '0;
	logic signed [15:0]    smp_y     = '0;
	logic                  res_ready = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int results_seen;
	int pending;
	int samples_sent   = 0;
	int settings_used  = 1;   // the reset setting counts as the first
	int burst_left     = 0;
	int rx_left        = 0;
	rx_mode_t rx_mode  = RX_OPEN;

	ahvi_sample_if smp ();
	ahvi_result_if res ();

	assign smp.valid   = smp_valid;
	assign smp.accel_x = smp_x;
	assign smp.accel_y = smp_y;
	assign res.ready   = res_ready;

	accel_highpass_velocity_integrator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	integrator_result_checker motion_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (smp),
		.res          (res),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// Result sink: switch between open, coin-toss, sparse and long-blocked
	// stretches, so that stalls land on every cycle of the result hold.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 400);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				res_ready <= 1'b1;
			end
			RX_COIN: begin
				res_ready <= ($urandom_range(0, 1) == 1);
			end
			RX_SPARSE: begin
				res_ready <= ($urandom_range(0, 15) == 0);
			end
			default: begin
				res_ready <= (rx_left % 37 == 0);
			end
		endcase
	end

	// Offer one sample and hold it until its transfer. Samples come in bursts;
	// between bursts drop valid for a random gap, sometimes none at all.
	task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
		int pick;
		int gap;
		if (burst_left == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				gap = 0;
			else if (pick < 7)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(5, 60);
			if (gap > 0) begin
				smp_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		smp_valid <= 1'b1;
		smp_x     <= x;
		smp_y     <= y;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		burst_left--;
		samples_sent++;
	endtask

	// Drop valid and wait until every sample so far has come back as a result.
	task automatic drain_results();
		smp_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_seen < samples_sent);
	endtask

	// Hold a register write for one edge; the caller lowers the enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Change both coefficients with the block idle, optionally poking a
	// spare index that must leave them alone.
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] alpha,
			input logic [CFG_DATA_W-1:0] step, input bit poke_spare);
		drain_results();
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_TIME_STEP, step);
		if (poke_spare)
			write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
				CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Random samples in runs: white noise, small signals within +-400, held
	// values the low-pass settles on, rails, and ramps.
	task automatic run_phase(input int count);
		accel_pattern_t     pattern = PAT_NOISE;
		int                 run_left = 0;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] hold_x = '0;
		logic signed [15:0] hold_y = '0;
		logic signed [15:0] ramp_x = '0;
		logic signed [15:0] ramp_y = '0;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				pattern  = accel_pattern_t'($urandom_range(0, 4));
				run_left = $urandom_range(1, 30);
				hold_x   = 16'($urandom);
				hold_y   = 16'($urandom);
				ramp_x   = 16'($urandom_range(0, 1024) - 512);
				ramp_y   = 16'($urandom_range(0, 1024) - 512);
			end
			run_left--;
			case (pattern)
				PAT_NOISE: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
				PAT_QUIET: begin
					x = 16'($urandom_range(0, 800) - 400);
					y = 16'($urandom_range(0, 800) - 400);
				end
				PAT_HOLD: begin
					x = hold_x;
					y = hold_y;
				end
				PAT_RAIL: begin
					x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
					y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				end
				default: begin
					x = hold_x;
					y = hold_y;
					hold_x = hold_x + ramp_x;
					hold_y = hold_y + ramp_y;
				end
			endcase
			send_sample(x, y);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// a write to a spare index straight after reset must not disturb
		// the reset coefficients used by the directed samples
		write_reg(REG_SPARE_FIRST, CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;

		foreach (DIRECTED_X[i])
			send_sample(DIRECTED_X[i], DIRECTED_Y[i]);

		// reset coefficients, then a random mild setting
		run_phase(PHASE_ITEMS);
		apply_setting(CFG_DATA_W'($urandom_range(0, 16'hffff)),
			CFG_DATA_W'($urandom_range(1, 3000)), 1'b1);
		run_phase(PHASE_ITEMS);
		// no retention: low-pass follows the sample, longest time step
		apply_setting(16'h0000, 16'hffff, 1'b0);
		run_phase(PHASE_ITEMS);
		// full retention with the longest step drives the integrators to the rails
		apply_setting(16'hffff, 16'hffff, 1'b1);
		run_phase(PHASE_ITEMS);
		// zero time step freezes velocity and displacement
		apply_setting(16'hffff, 16'h0000, 1'b0);
		run_phase(PHASE_ITEMS);
		apply_setting(16'h0000, 16'h0000, 1'b1);
		run_phase(PHASE_ITEMS);
		// back to the reset values, written explicitly
		apply_setting(ALPHA_RESET, TIME_STEP_RESET, 1'b0);
		run_phase(PHASE_ITEMS);
		apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1);
		run_phase(PHASE_ITEMS);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d samples under %0d coefficient settings, %0d results checked",
			samples_sent, settings_used, results_seen);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Give up well beyond the slowest legal run.
	initial begin
		#20ms;
		$display("timeout with %0d of %0d results returned", results_seen, samples_sent);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/ahvi_pkg.sv
src/ahvi_if.sv
src/ahvi_mac.sv
src/ahvi_seq.sv
src/accel_highpass_velocity_integrator.sv
tb/integrator_result_checker.sv
tb/tb_accel_highpass_velocity_integrator.sv
